[design/udc_pkg.sv]
package udc_pkg;

  localparam int unsigned HDR_BYTES = 8;
  localparam int unsigned MAX_PAYLOAD_DEF = 2048;
  localparam logic [15:0] PROTO_WORD = 16'h0011;

  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_IP = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_IP = 1'b1;

  typedef enum logic [2:0] {
    FMT_OK       = 3'd0,
    FMT_SHORT    = 3'd1,
    FMT_BAD_LEN  = 3'd2,
    FMT_TOO_LONG = 3'd3,
    FMT_MISMATCH = 3'd4
  } fmt_status_t;

  // fold a sum of up to eight 16-bit words into a ones-complement word
  function automatic logic [15:0] oc_fold(input logic [18:0] s);
    logic [16:0] t;
    logic [16:0] u;
    t = {1'b0, s[15:0]} + {14'd0, s[18:16]};
    u = {1'b0, t[15:0]} + {16'd0, t[16]};
    return u[15:0];
  endfunction

endpackage

[design/udc_final_sum.sv]
module udc_final_sum (
  input  logic [15:0] run_sum,
  input  logic [15:0] last_word,
  input  logic [15:0] ip_sum,
  input  logic [15:0] byte_cnt,
  output logic [15:0] csum
);

  logic [18:0] total;

  assign total = {3'd0, run_sum} + {3'd0, last_word} + {3'd0, ip_sum} + {3'd0, byte_cnt};
  assign csum  = ~udc_pkg::oc_fold(total);

endmodule

[design/udp_datagram_checker_core.sv]
// a last byte passes through the input register and then the result register, which drives out_valid
// throughput: one byte per cycle; input stalls only while a result waits in the
//   output register and the next registered byte is also a last byte
// config writes land in the IP registers, and the pseudo-header sum register is updated from them
// synchronous active-low reset clears config, datagram state and both valids
module udp_datagram_checker_core #(
  parameter int unsigned MAX_PAYLOAD = udc_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [udc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [udc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     in_data_byte,
  input  logic                           in_last_byte,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [15:0]                    out_source_port,
  output logic [15:0]                    out_dest_port,
  output logic [15:0]                    out_length_field,
  output logic [15:0]                    out_checksum_field,
  output logic [15:0]                    out_received_count,
  output logic [15:0]                    out_computed_checksum,
  output logic                           out_checksum_ok,
  output logic [2:0]                     out_format_status
);

  localparam logic [16:0] LEN_LIMIT = 17'(MAX_PAYLOAD + udc_pkg::HDR_BYTES);

  logic [31:0] src_ip_r, dst_ip_r;
  logic [15:0] ip_sum_r;

  logic        in_valid_r;
  logic [7:0]  in_data_r;
  logic        in_last_r;

  logic [15:0] run_sum_r, run_sum_nxt;
  logic [7:0]  hold_r, hold_nxt;
  logic        odd_r, odd_nxt;
  logic [15:0] byte_cnt_r, byte_cnt_nxt;
  logic [15:0] hdr_r [4];
  logic [15:0] hdr_nxt [4];

  logic        process;
  logic [15:0] cur_word;
  logic [16:0] pair_sum;
  logic [15:0] csum;
  logic [15:0] len;
  udc_pkg::fmt_status_t status;

  logic        out_valid_r;
  logic [15:0] out_hdr_r [4];
  logic [15:0] out_cnt_r;
  logic [15:0] out_csum_r;
  udc_pkg::fmt_status_t out_status_r;

  // config registers and pseudo-header partial sum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_ip_r <= '0;
      dst_ip_r <= '0;
      ip_sum_r <= '0;
    end else begin
      if (cfg_we && cfg_index == udc_pkg::REG_SOURCE_IP) begin
        src_ip_r <= cfg_wdata;
      end
      if (cfg_we && cfg_index == udc_pkg::REG_DEST_IP) begin
        dst_ip_r <= cfg_wdata;
      end
      ip_sum_r <= udc_pkg::oc_fold({3'd0, src_ip_r[31:16]} + {3'd0, src_ip_r[15:0]}
                                   + {3'd0, dst_ip_r[31:16]} + {3'd0, dst_ip_r[15:0]}
                                   + {3'd0, udc_pkg::PROTO_WORD});
    end
  end

  assign process  = in_valid_r && (!in_last_r || !out_valid_r || out_ready);
  assign in_ready = !in_valid_r || process;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      in_data_r <= in_data_byte;
      in_last_r <= in_last_byte;
    end
  end

  // per-byte update
  assign cur_word = odd_r ? {hold_r, in_data_r} : {in_data_r, 8'h00};
  assign pair_sum = {1'b0, run_sum_r} + {1'b0, cur_word};

  always_comb begin
    run_sum_nxt  = odd_r ? (pair_sum[15:0] + {15'd0, pair_sum[16]}) : run_sum_r;
    hold_nxt     = odd_r ? hold_r : in_data_r;
    odd_nxt      = !odd_r;
    byte_cnt_nxt = (&byte_cnt_r) ? byte_cnt_r : byte_cnt_r + 16'd1;
    for (int i = 0; i < 4; i++) begin
      hdr_nxt[i] = hdr_r[i];
    end
    if (byte_cnt_r[15:3] == '0) begin
      if (!byte_cnt_r[0]) begin
        hdr_nxt[byte_cnt_r[2:1]] = {in_data_r, 8'h00};
      end else begin
        hdr_nxt[byte_cnt_r[2:1]] = {hdr_r[byte_cnt_r[2:1]][15:8], in_data_r};
      end
    end
  end

  udc_final_sum u_final_sum (
    .run_sum   (run_sum_r),
    .last_word (cur_word),
    .ip_sum    (ip_sum_r),
    .byte_cnt  (byte_cnt_nxt),
    .csum      (csum)
  );

  assign len = hdr_nxt[2];

  always_comb begin
    if (byte_cnt_nxt[15:3] == '0) begin
      status = udc_pkg::FMT_SHORT;
    end else if (len[15:3] == '0) begin
      status = udc_pkg::FMT_BAD_LEN;
    end else if ({1'b0, len} > LEN_LIMIT) begin
      status = udc_pkg::FMT_TOO_LONG;
    end else if (len != byte_cnt_nxt) begin
      status = udc_pkg::FMT_MISMATCH;
    end else begin
      status = udc_pkg::FMT_OK;
    end
  end

  // datagram state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_sum_r  <= '0;
      hold_r     <= '0;
      odd_r      <= 1'b0;
      byte_cnt_r <= '0;
      for (int i = 0; i < 4; i++) begin
        hdr_r[i] <= '0;
      end
    end else if (process) begin
      if (in_last_r) begin
        run_sum_r  <= '0;
        hold_r     <= '0;
        odd_r      <= 1'b0;
        byte_cnt_r <= '0;
        for (int i = 0; i < 4; i++) begin
          hdr_r[i] <= '0;
        end
      end else begin
        run_sum_r  <= run_sum_nxt;
        hold_r     <= hold_nxt;
        odd_r      <= odd_nxt;
        byte_cnt_r <= byte_cnt_nxt;
        for (int i = 0; i < 4; i++) begin
          hdr_r[i] <= hdr_nxt[i];
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (process && in_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (process && in_last_r) begin
      for (int i = 0; i < 4; i++) begin
        out_hdr_r[i] <= hdr_nxt[i];
      end
      out_cnt_r    <= byte_cnt_nxt;
      out_csum_r   <= csum;
      out_status_r <= status;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_source_port       = out_hdr_r[0];
  assign out_dest_port         = out_hdr_r[1];
  assign out_length_field      = out_hdr_r[2];
  assign out_checksum_field    = out_hdr_r[3];
  assign out_received_count    = out_cnt_r;
  assign out_computed_checksum = out_csum_r;
  assign out_checksum_ok       = (out_csum_r == 16'd0);
  assign out_format_status     = out_status_r;

  // input side stalls only behind a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (in_valid_r && in_last_r && out_valid_r && !out_ready))
    else $error("input stalled without a waiting result");

  // state is cleared after a last byte
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (process && in_last_r) |=> (byte_cnt_r == 16'd0 && !odd_r && run_sum_r == 16'd0))
    else $error("datagram state not cleared");

  // ok status means the length field matches the count
  a_ok_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == udc_pkg::FMT_OK) |-> (out_hdr_r[2] == out_cnt_r))
    else $error("ok status with length mismatch");

  // pseudo-header always contributes a nonzero word, so the sum never folds to zero
  a_sum_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_cnt_r != 16'd0) |-> (out_csum_r != 16'hFFFF))
    else $error("folded sum is zero");

endmodule
